// ===== rtl/ash_pkg.sv =====
package ash_pkg;

    // Table geometry
    localparam int BUCKETS = 64;

    // Field widths
    localparam int SIZE_W         = 32;
    localparam int COUNT_W        = 32;
    localparam int SUM_W          = 48;
    localparam int LIVE_W         = 40;
    localparam int STATUS_W       = 3;
    localparam int BUCKET_INDEX_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [LIVE_W-1:0]  LIVE_MAX  = {LIVE_W{1'b1}};

    // Event kinds on the operation field
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_NEW       = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_UNMATCHED = 3'd4,
        ST_UNTRACKED = 3'd5
    } status_t;

    // Update applied by the selected cell at commit
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_INC   = 2'd1,
        MODE_CLAIM = 2'd2,
        MODE_DEC   = 2'd3
    } cell_mode_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic       look;
        logic       commit;
        cell_mode_t mode;
    } cell_cmd_t;

endpackage

// ===== rtl/ash_if.sv =====
interface ash_in_if
    import ash_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SIZE_W-1:0] size;
    logic              was_tracked;

    modport source (output valid, output operation, output size, output was_tracked,
                    input ready);
    modport sink   (input valid, input operation, input size, input was_tracked,
                    output ready);
endinterface

interface ash_out_if
    import ash_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [BUCKET_INDEX_W-1:0] bucket_index;
    logic [COUNT_W-1:0]        bucket_count;
    logic [SUM_W-1:0]          total_allocated;
    logic [SUM_W-1:0]          total_freed;
    logic [SUM_W-1:0]          outstanding_bytes;
    logic [LIVE_W-1:0]         outstanding_count;

    modport source (output valid, output status, output bucket_index, output bucket_count,
                    output total_allocated, output total_freed, output outstanding_bytes,
                    output outstanding_count, input ready);
    modport sink   (input valid, input status, input bucket_index, input bucket_count,
                    input total_allocated, input total_freed, input outstanding_bytes,
                    input outstanding_count, output ready);
endinterface

// ===== rtl/ash_cell.sv =====
module ash_cell
    import ash_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SIZE_W-1:0]  key,
    input  cell_cmd_t          cmd,
    input  logic               hit_in,
    input  logic               empty_in,
    output logic               hit_out,
    output logic               empty_out,
    output logic               sat_sel,
    output logic               touched,
    output logic [COUNT_W-1:0] count_sel
);

    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               hit_sel_reg;
    logic               empty_sel_reg;
    logic               sat_reg;
    logic               touched_reg;

    logic cell_hit;
    logic cell_empty;

    // Compare locally, pass the claim marks on to the next cell
    assign cell_hit   = (count_reg != '0) && (size_reg == key);
    assign cell_empty = (count_reg == '0);
    assign hit_out    = hit_in | cell_hit;
    assign empty_out  = empty_in | cell_empty;

    assign sat_sel   = hit_sel_reg & sat_reg;
    assign touched   = touched_reg;
    assign count_sel = touched_reg ? count_reg : '0;

    // Latch first-match flags on look
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_sel_reg   <= 1'b0;
            empty_sel_reg <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else if (cmd.look)
        begin
            hit_sel_reg   <= cell_hit & ~hit_in;
            empty_sel_reg <= cell_empty & ~empty_in;
            sat_reg       <= (count_reg == COUNT_MAX);
        end
    end

    // Apply the update if this cell was selected
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            touched_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            unique case (cmd.mode)
                MODE_INC:
                begin
                    touched_reg <= hit_sel_reg;
                    if (hit_sel_reg && !sat_reg)
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                end
                MODE_CLAIM:
                begin
                    touched_reg <= empty_sel_reg;
                    if (empty_sel_reg)
                    begin
                        count_reg <= COUNT_W'(1);
                    end
                end
                MODE_DEC:
                begin
                    touched_reg <= hit_sel_reg;
                    if (hit_sel_reg)
                    begin
                        count_reg <= count_reg - COUNT_W'(1);
                    end
                end
                MODE_NONE:
                begin
                    touched_reg <= 1'b0;
                end
                default:
                begin
                    touched_reg <= 1'b0;
                end
            endcase
        end
    end

    // Store the size when claiming an empty bucket
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (cmd.mode == MODE_CLAIM) && empty_sel_reg)
        begin
            size_reg <= key;
        end
    end

endmodule

// ===== rtl/ash_chain.sv =====
module ash_chain
    import ash_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [SIZE_W-1:0]         key,
    input  cell_cmd_t                 cmd,
    output logic                      any_hit,
    output logic                      any_empty,
    output logic                      hit_sat,
    output logic [BUCKET_INDEX_W-1:0] sel_index,
    output logic [COUNT_W-1:0]        sel_count
);

    logic [BUCKETS:0]   hit_link;
    logic [BUCKETS:0]   empty_link;
    logic [BUCKETS-1:0] sat_vec;
    logic [BUCKETS-1:0] touched_vec;
    logic [COUNT_W-1:0] count_vec [BUCKETS];

    assign hit_link[0]   = 1'b0;
    assign empty_link[0] = 1'b0;
    assign any_hit       = hit_link[BUCKETS];
    assign any_empty     = empty_link[BUCKETS];
    assign hit_sat       = |sat_vec;

    // Row of buckets, lowest index first
    for (genvar i = 0; i < BUCKETS; i++)
    begin : g_cell
        ash_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key),
            .cmd       (cmd),
            .hit_in    (hit_link[i]),
            .empty_in  (empty_link[i]),
            .hit_out   (hit_link[i+1]),
            .empty_out (empty_link[i+1]),
            .sat_sel   (sat_vec[i]),
            .touched   (touched_vec[i]),
            .count_sel (count_vec[i])
        );
    end

    // Gather index and count of the touched bucket (at most one)
    always_comb
    begin
        sel_index = '0;
        sel_count = '0;
        for (int i = 0; i < BUCKETS; i++)
        begin
            if (touched_vec[i])
            begin
                sel_index = sel_index | BUCKET_INDEX_W'(i);
            end
            sel_count = sel_count | count_vec[i];
        end
    end

endmodule

// ===== rtl/allocation_size_histogram.sv =====
// Allocation size histogram.
// in_ch (sink) takes one event: operation (0 allocation, 1 free), size and
// was_tracked; it is accepted when valid and ready are both high.
// out_ch (source) returns exactly one result per event: status, bucket_index,
// bucket_count, both running totals, outstanding bytes and outstanding count.
// cfg_we/cfg_wdata write tracking_enabled; write it only while the block is idle.
// Each event passes through accept, a look cycle in which the size is compared
// in all 64 bucket cells at once and the first-match marks ripple down the row,
// a commit cycle that updates the chosen cell and the totals, and a report cycle
// that loads the output register. Ready is high only in the idle state, so a new
// event is taken only after the last has left the report cycle. The output
// register holds a result while the receiver stalls; the block then takes
// one more event, held in the report cycle until the output register frees up.
// Reset clears all bucket counts, the totals, tracking_enabled and the output
// valid; the block comes out of reset ready.
module allocation_size_histogram
    import ash_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    ash_in_if.sink   in_ch,
    ash_out_if.source out_ch
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    state_t             state_reg;
    logic               tracking_reg;
    logic               op_reg;
    logic               tracked_reg;
    logic [SIZE_W-1:0]  key_reg;
    status_t            status_reg;
    logic [SUM_W-1:0]   alloc_sum_reg;
    logic [SUM_W-1:0]   freed_sum_reg;
    logic [LIVE_W-1:0]  live_reg;

    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [BUCKET_INDEX_W-1:0] out_index_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic [SUM_W-1:0]          out_alloc_reg;
    logic [SUM_W-1:0]          out_freed_reg;
    logic [SUM_W-1:0]          out_outst_reg;
    logic [LIVE_W-1:0]         out_live_reg;

    cell_cmd_t                 cmd;
    cell_mode_t                mode;
    status_t                   status_next;
    logic                      any_hit;
    logic                      any_empty;
    logic                      hit_sat;
    logic [BUCKET_INDEX_W-1:0] sel_index;
    logic [COUNT_W-1:0]        sel_count;
    logic                      in_fire;
    logic                      out_free;
    logic                      live_inc;
    logic                      live_dec;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid & in_ch.ready;
    assign out_free    = ~out_valid_reg | out_ch.ready;

    // Choose the cell update from the chain result
    always_comb
    begin
        mode        = MODE_NONE;
        status_next = ST_UNTRACKED;
        live_inc    = 1'b0;
        live_dec    = 1'b0;
        if (tracked_reg)
        begin
            if (op_reg == OP_ALLOC)
            begin
                priority if (any_hit)
                begin
                    mode        = MODE_INC;
                    status_next = ST_HIT;
                    live_inc    = ~hit_sat;
                end
                else if (any_empty)
                begin
                    mode        = MODE_CLAIM;
                    status_next = ST_NEW;
                    live_inc    = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            else
            begin
                if (any_hit)
                begin
                    mode        = MODE_DEC;
                    status_next = ST_FREED;
                    live_dec    = 1'b1;
                end
                else
                begin
                    status_next = ST_UNMATCHED;
                end
            end
        end
    end

    assign cmd.look   = (state_reg == S_LOOK);
    assign cmd.commit = (state_reg == S_COMMIT);
    assign cmd.mode   = mode;

    ash_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .cmd       (cmd),
        .any_hit   (any_hit),
        .any_empty (any_empty),
        .hit_sat   (hit_sat),
        .sel_index (sel_index),
        .sel_count (sel_count)
    );

    // Hold the tracking register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            tracking_reg <= cfg_wdata;
        end
    end

    // Capture the item on accept and the status at commit
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= in_ch.operation;
            key_reg     <= in_ch.size;
            tracked_reg <= (in_ch.operation == OP_FREE) ? in_ch.was_tracked : tracking_reg;
        end
        if (state_reg == S_COMMIT)
        begin
            status_reg <= status_next;
        end
    end

    // Advance the sequencer and update totals at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_sum_reg <= '0;
            freed_sum_reg <= '0;
            live_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    state_reg <= S_REPORT;
                    if (tracked_reg && (op_reg == OP_ALLOC))
                    begin
                        alloc_sum_reg <= alloc_sum_reg + SUM_W'(key_reg);
                    end
                    if (tracked_reg && (op_reg == OP_FREE))
                    begin
                        freed_sum_reg <= freed_sum_reg + SUM_W'(key_reg);
                    end
                    if (live_inc && (live_reg != LIVE_MAX))
                    begin
                        live_reg <= live_reg + LIVE_W'(1);
                    end
                    else if (live_dec && (live_reg != '0))
                    begin
                        live_reg <= live_reg - LIVE_W'(1);
                    end
                end
                S_REPORT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_REPORT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_REPORT) && out_free)
        begin
            out_status_reg <= status_reg;
            out_index_reg  <= sel_index;
            out_count_reg  <= sel_count;
            out_alloc_reg  <= alloc_sum_reg;
            out_freed_reg  <= freed_sum_reg;
            out_outst_reg  <= alloc_sum_reg - freed_sum_reg;
            out_live_reg   <= live_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.status            = out_status_reg;
    assign out_ch.bucket_index      = out_index_reg;
    assign out_ch.bucket_count      = out_count_reg;
    assign out_ch.total_allocated   = out_alloc_reg;
    assign out_ch.total_freed       = out_freed_reg;
    assign out_ch.outstanding_bytes = out_outst_reg;
    assign out_ch.outstanding_count = out_live_reg;

endmodule

// ===== test/tb_allocation_size_histogram.sv =====
`timescale 1ns / 1ps

module tb_allocation_size_histogram;
    import ash_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int POOL_DEPTH = 128;

    typedef enum int {
        IDLE_RECV_HEAVY,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    typedef struct packed {
        status_t                   status;
        logic [BUCKET_INDEX_W-1:0] bucket_index;
        logic [COUNT_W-1:0]        bucket_count;
        logic [SUM_W-1:0]          total_allocated;
        logic [SUM_W-1:0]          total_freed;
        logic [SUM_W-1:0]          outstanding_bytes;
        logic [LIVE_W-1:0]         outstanding_count;
    } histogram_result_t;

    // Bucket table model and the queue of results it has predicted
    class size_histogram_tracker;
        logic [SIZE_W-1:0]  size_tab[BUCKETS];
        logic [COUNT_W-1:0] count_tab[BUCKETS];
        logic [SUM_W-1:0]   alloc_sum;
        logic [SUM_W-1:0]   freed_sum;
        logic [LIVE_W-1:0]  live;
        logic               tracking;
        histogram_result_t  pending_results[$];
        int                 errors;

        function new();
            for (int i = 0; i < BUCKETS; i++)
            begin
                size_tab[i] = '0;
                count_tab[i] = '0;
            end
            alloc_sum = '0;
            freed_sum = '0;
            live = '0;
            tracking = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Lowest live bucket holding this size, -1 when none
        function int find_live(logic [SIZE_W-1:0] sz);
            for (int i = 0; i < BUCKETS; i++)
            begin
                if (count_tab[i] != '0 && size_tab[i] == sz)
                    return i;
            end
            return -1;
        endfunction

        // Apply one accepted event to the table and queue its result
        function void note_event(logic op, logic [SIZE_W-1:0] sz, logic tr);
            histogram_result_t r;
            int                slot;
            r = '0;
            r.status = ST_UNTRACKED;
            if (op == OP_ALLOC)
            begin
                if (tracking)
                begin
                    alloc_sum = alloc_sum + SUM_W'(sz);
                    slot = find_live(sz);
                    if (slot >= 0)
                    begin
                        if (count_tab[slot] != COUNT_MAX)
                        begin
                            count_tab[slot]++;
                            if (live != LIVE_MAX)
                                live++;
                        end
                        r.status = ST_HIT;
                        r.bucket_index = BUCKET_INDEX_W'(slot);
                        r.bucket_count = count_tab[slot];
                    end
                    else
                    begin
                        // claim the lowest empty bucket
                        for (int i = BUCKETS - 1; i >= 0; i--)
                        begin
                            if (count_tab[i] == '0)
                                slot = i;
                        end
                        if (slot >= 0)
                        begin
                            size_tab[slot] = sz;
                            count_tab[slot] = COUNT_W'(1);
                            if (live != LIVE_MAX)
                                live++;
                            r.status = ST_NEW;
                            r.bucket_index = BUCKET_INDEX_W'(slot);
                            r.bucket_count = COUNT_W'(1);
                        end
                        else
                            r.status = ST_FULL;
                    end
                end
            end
            else if (tr)
            begin
                freed_sum = freed_sum + SUM_W'(sz);
                slot = find_live(sz);
                if (slot >= 0)
                begin
                    count_tab[slot]--;
                    if (count_tab[slot] == '0)
                        size_tab[slot] = '0;
                    if (live != '0)
                        live--;
                    r.status = ST_FREED;
                    r.bucket_index = BUCKET_INDEX_W'(slot);
                    r.bucket_count = count_tab[slot];
                end
                else
                    r.status = ST_UNMATCHED;
            end
            r.total_allocated = alloc_sum;
            r.total_freed = freed_sum;
            r.outstanding_bytes = alloc_sum - freed_sum;
            r.outstanding_count = live;
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [63:0] got_val, logic [63:0] want_val);
            $display("mismatch %s: got %0h, expected %0h", what, got_val, want_val);
            errors++;
        endtask

        // Compare one result item with the oldest prediction
        task check_result(histogram_result_t got);
            histogram_result_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected result, status", 64'(got.status), '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.bucket_index !== want.bucket_index)
                report("bucket_index", 64'(got.bucket_index), 64'(want.bucket_index));
            if (got.bucket_count !== want.bucket_count)
                report("bucket_count", 64'(got.bucket_count), 64'(want.bucket_count));
            if (got.total_allocated !== want.total_allocated)
                report("total_allocated", 64'(got.total_allocated),
                       64'(want.total_allocated));
            if (got.total_freed !== want.total_freed)
                report("total_freed", 64'(got.total_freed), 64'(want.total_freed));
            if (got.outstanding_bytes !== want.outstanding_bytes)
                report("outstanding_bytes", 64'(got.outstanding_bytes),
                       64'(want.outstanding_bytes));
            if (got.outstanding_count !== want.outstanding_count)
                report("outstanding_count", 64'(got.outstanding_count),
                       64'(want.outstanding_count));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ash_in_if  in_ch ();
    ash_out_if out_ch ();

    size_histogram_tracker tracker;
    logic [SIZE_W-1:0]     size_pool[POOL_DEPTH];
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    stall_cycles = 0;

    allocation_size_histogram i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run when neither channel moves an item for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", stall_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_RECV_HEAVY:
            begin
                send_idle_pct = 35;
                recv_idle_pct = 65;
            end
            IDLE_SEND_HEAVY:
            begin
                send_idle_pct = 65;
                recv_idle_pct = 35;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Take result items, stalling at random
    task automatic receive_results();
        histogram_result_t got;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.status = status_t'(out_ch.status);
                got.bucket_index = out_ch.bucket_index;
                got.bucket_count = out_ch.bucket_count;
                got.total_allocated = out_ch.total_allocated;
                got.total_freed = out_ch.total_freed;
                got.outstanding_bytes = out_ch.outstanding_bytes;
                got.outstanding_count = out_ch.outstanding_count;
                tracker.check_result(got);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    endtask

    // Offer one event item, idling at random first, and hold it until taken
    task automatic send_event(logic op, logic [SIZE_W-1:0] sz, logic tr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.size <= sz;
        in_ch.was_tracked <= tr;
        do
            @(posedge clk);
        while (!in_ch.ready);
        tracker.note_event(op, sz, tr);
    endtask

    // Hold the sender until every predicted result has come, then settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tracking(logic value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.tracking = value;
    endtask

    // Random events drawn mostly from a pool of sizes so buckets get reused
    task automatic run_random(int count, int pool_n, int alloc_pct, idle_mode_t mode);
        logic              op;
        logic [SIZE_W-1:0] sz;
        logic              tr;
        set_idling(mode);
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            if ($urandom_range(9) == 0)
                sz = $urandom;
            else
                sz = size_pool[$urandom_range(pool_n - 1)];
            tr = ($urandom_range(99) < 85);
            send_event(op, sz, tr);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_ALLOC;
        in_ch.size = '0;
        in_ch.was_tracked = 1'b0;
        tracker = new();
        size_pool[0] = '0;
        size_pool[1] = '1;
        size_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_DEPTH; i++)
            size_pool[i] = $urandom;
        set_idling(IDLE_RECV_HEAVY);
        fork
            receive_results();
        join_none
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tracking off after reset: allocations pass untracked, tracked frees count
        send_event(OP_ALLOC, '0, 1'b0);
        send_event(OP_ALLOC, '1, 1'b1);
        send_event(OP_FREE, 32'd5, 1'b0);
        send_event(OP_FREE, '1, 1'b1);

        // Tracking on: claim, hit, empty and reclaim buckets
        write_tracking(1'b1);
        send_event(OP_ALLOC, '0, 1'b0);
        send_event(OP_ALLOC, '0, 1'b1);
        send_event(OP_ALLOC, '1, 1'b0);
        send_event(OP_ALLOC, 32'h8000_0001, 1'b0);
        send_event(OP_FREE, '0, 1'b1);
        send_event(OP_FREE, '0, 1'b1);
        send_event(OP_FREE, '0, 1'b1);
        send_event(OP_ALLOC, 32'h0000_1234, 1'b1);
        send_event(OP_FREE, '1, 1'b0);
        send_event(OP_FREE, '1, 1'b1);
        send_event(OP_ALLOC, '0, 1'b0);
        send_event(OP_FREE, 32'h8000_0001, 1'b1);
        send_event(OP_ALLOC, 32'h7FFF_FFFE, 1'b1);
        send_event(OP_FREE, 32'h7FFF_FFFE, 1'b1);

        // Allocation heavy over many sizes fills the table
        write_tracking(1'b1);
        run_random(300, 100, 75, IDLE_RECV_HEAVY);

        // Free heavy drains it again
        drain_results();
        run_random(300, 100, 25, IDLE_SEND_HEAVY);

        // Tracking off: allocations untracked, tracked frees still drain
        write_tracking(1'b0);
        run_random(150, 100, 50, IDLE_NONE);

        // Few sizes, balanced traffic, no idling
        write_tracking(1'b1);
        run_random(250, 10, 55, IDLE_NONE);

        drain_results();
        if (tracker.pending() != 0)
            tracker.report("results never arrived", 64'(tracker.pending()), '0);
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
